// ===== rtl/core/wsp_pkg.sv =====
`timescale 1ns / 1ps

package wsp_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
	localparam int LEN_W       = 5;
	localparam int CFG_W       = 64;
	localparam int CHAR_W      = 8;
	localparam int POS_W       = 16;
	localparam int COUNT_W     = 32;

	localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

	localparam logic [1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

	localparam logic KIND_MATCH = 1'b0;
	localparam logic KIND_TOTAL = 1'b1;

	// One window slot: a text byte and where it stood in the text.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [POS_W-1:0]  line;
		logic [POS_W-1:0]  column;
	} entry_t;

	// Compare setup shared by every cell of the window.
	typedef struct packed {
		logic [MAX_PATTERN*CHAR_W-1:0] pattern;
		logic [FILL_W-1:0]             len;
	} cmp_cfg_t;

	// A length of zero acts as one, anything above the window as the window.
	function automatic logic [FILL_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		logic [FILL_W-1:0] res;
		if (len == '0) begin
			res = FILL_W'(1);
		end else if (int'(len) > MAX_PATTERN) begin
			res = FILL_W'(MAX_PATTERN);
		end else begin
			res = FILL_W'(len);
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/wsp_cell.sv =====
`timescale 1ns / 1ps

module wsp_cell (
	input  logic              clk,
	input  logic              shift,
	input  logic [wsp_pkg::IDX_W-1:0] pos,
	input  wsp_pkg::cmp_cfg_t cfg,
	input  wsp_pkg::entry_t   entry_in,
	output wsp_pkg::entry_t   entry,
	output logic              hit
);

	wsp_pkg::entry_t                 entry_q;
	logic [wsp_pkg::FILL_W-1:0]      span;
	logic [wsp_pkg::FILL_W-1:0]      k_full;
	logic [wsp_pkg::IDX_W-1:0]       k;
	logic                            in_use;
	logic [wsp_pkg::CHAR_W-1:0]      want;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= entry_in;
		end
	end

	// The pattern sits right-aligned in the window: this cell holds pattern
	// byte pos + len - MAX_PATTERN when that index is not negative.
	always_comb begin
		span   = wsp_pkg::FILL_W'(pos) + cfg.len;
		in_use = span >= wsp_pkg::FILL_W'(wsp_pkg::MAX_PATTERN);
		k_full = span - wsp_pkg::FILL_W'(wsp_pkg::MAX_PATTERN);
		k      = k_full[wsp_pkg::IDX_W-1:0];
		want   = cfg.pattern[k*wsp_pkg::CHAR_W +: wsp_pkg::CHAR_W];
		hit    = !in_use || (entry_q.ch == want);
	end

	assign entry = entry_q;

endmodule

// ===== rtl/core/whitespace_skipping_pattern_matcher.sv =====
`timescale 1ns / 1ps

// Path: an accepted byte goes to the stage-1 flags (non-blank ones also to the
// window), its result then to the output register. Throughput: one byte per
// cycle unless the output stalls; the sixteen-cell compare and the count
// update share a stage. Reset: arst_n at once clears match count, window fill
// and pattern bytes and sets pattern length and text position to one.
module whitespace_skipping_pattern_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_byte
	input  logic        s_tlast,  // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [15:0] match_line, [31:16] match_column,
	                              // [63:32] match_count
	output logic        m_tuser,  // result_kind
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int MAXP = wsp_pkg::MAX_PATTERN;
	localparam int PW   = wsp_pkg::POS_W;

	logic [wsp_pkg::CFG_W-1:0]   pat_low_q;
	logic [wsp_pkg::CFG_W-1:0]   pat_high_q;
	logic [wsp_pkg::LEN_W-1:0]   pat_len_q;
	wsp_pkg::cmp_cfg_t           cmp_cfg;

	logic                        adv;
	logic                        accept;
	logic                        is_blank;
	logic                        push;
	wsp_pkg::entry_t             new_entry;

	logic [wsp_pkg::FILL_W-1:0]  fill_q;
	logic [PW-1:0]               line_q;
	logic [PW-1:0]               col_q;

	logic                        valid_s1;
	logic                        eoi_s1;
	logic                        push_s1;

	wsp_pkg::entry_t             cell_entry [MAXP];
	logic [MAXP-1:0]             cell_hit;
	logic [wsp_pkg::FILL_W-1:0]  base_full;
	logic [wsp_pkg::IDX_W-1:0]   base;
	logic                        match;

	logic                        m_valid_q;
	logic                        kind_q;
	logic [PW-1:0]               out_line_q;
	logic [PW-1:0]               out_col_q;
	logic [wsp_pkg::COUNT_W-1:0] out_count_q;
	logic [wsp_pkg::COUNT_W-1:0] count_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= wsp_pkg::LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				wsp_pkg::REG_PATTERN_LOW:    pat_low_q  <= cfg_data;
				wsp_pkg::REG_PATTERN_HIGH:   pat_high_q <= cfg_data;
				wsp_pkg::REG_PATTERN_LENGTH: pat_len_q  <= cfg_data[wsp_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cmp_cfg.pattern = {pat_high_q, pat_low_q};
	assign cmp_cfg.len     = wsp_pkg::eff_len(pat_len_q);

	// The whole pipe moves whenever the output register is free or drained.
	assign adv      = !m_valid_q || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;
	assign is_blank = (s_tdata == wsp_pkg::CHAR_TAB) || (s_tdata == wsp_pkg::CHAR_SPACE) ||
	                  (s_tdata == wsp_pkg::CHAR_NEWLINE);
	assign push     = accept && !s_tlast && !is_blank;

	assign new_entry.ch     = s_tdata;
	assign new_entry.line   = line_q;
	assign new_entry.column = col_q;

	// Text position and window fill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			line_q <= PW'(1);
			col_q  <= PW'(1);
		end else if (accept) begin
			if (s_tlast) begin
				fill_q <= '0;
				line_q <= PW'(1);
				col_q  <= PW'(1);
			end else begin
				if (s_tdata == wsp_pkg::CHAR_NEWLINE) begin
					col_q <= PW'(1);
					if (line_q != '1) begin
						line_q <= line_q + PW'(1);
					end
				end else if (col_q != '1) begin
					col_q <= col_q + PW'(1);
				end
				if (push && (fill_q < wsp_pkg::FILL_W'(MAXP))) begin
					fill_q <= fill_q + wsp_pkg::FILL_W'(1);
				end
			end
		end
	end

	// The window: cell MAXP-1 holds the newest byte.
	for (genvar j = 0; j < MAXP; j++) begin : g_cell
		wsp_pkg::entry_t entry_in;
		if (j == MAXP - 1) begin : g_head
			assign entry_in = new_entry;
		end else begin : g_link
			assign entry_in = cell_entry[j+1];
		end
		wsp_cell u_cell (
			.clk      (clk),
			.shift    (push),
			.pos      (wsp_pkg::IDX_W'(j)),
			.cfg      (cmp_cfg),
			.entry_in (entry_in),
			.entry    (cell_entry[j]),
			.hit      (cell_hit[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			eoi_s1   <= 1'b0;
			push_s1  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			eoi_s1   <= s_tlast;
			push_s1  <= push;
		end
	end

	assign base_full = wsp_pkg::FILL_W'(MAXP) - cmp_cfg.len;
	assign base      = base_full[wsp_pkg::IDX_W-1:0];
	assign match     = valid_s1 && !eoi_s1 && push_s1 && (fill_q >= cmp_cfg.len) && (&cell_hit);

	// Compare stage: the window already holds the byte pushed with the stage-1 flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			kind_q    <= wsp_pkg::KIND_MATCH;
			count_q   <= '0;
		end else if (adv) begin
			m_valid_q <= valid_s1 && (eoi_s1 || match);
			if (valid_s1 && eoi_s1) begin
				kind_q  <= wsp_pkg::KIND_TOTAL;
				count_q <= '0;
			end else if (match) begin
				kind_q <= wsp_pkg::KIND_MATCH;
				if (count_q != '1) begin
					count_q <= count_q + wsp_pkg::COUNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (valid_s1 && eoi_s1) begin
				out_line_q  <= '0;
				out_col_q   <= '0;
				out_count_q <= count_q;
			end else if (match) begin
				out_line_q  <= cell_entry[base].line;
				out_col_q   <= cell_entry[base].column;
				out_count_q <= (count_q != '1) ? count_q + wsp_pkg::COUNT_W'(1) : count_q;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {out_count_q, out_col_q, out_line_q};

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= wsp_pkg::FILL_W'(MAXP))
		else $error("window fill beyond window depth");

	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=>
		(fill_q == '0 && line_q == PW'(1) && col_q == PW'(1)))
		else $error("end of input did not clear the text position");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !(valid_s1 && eoi_s1)) |=> (count_q >= $past(count_q)))
		else $error("match count went down without an end of input");
`endif

endmodule
